>>> rtl/lfu_cache_with_timeout_unit_defines.svh
// Assertion macros shared by the cache RTL.
`ifndef LFU_CACHE_WITH_TIMEOUT_UNIT_DEFINES_SVH
`define LFU_CACHE_WITH_TIMEOUT_UNIT_DEFINES_SVH

// Implication checked on every rising edge, disabled during reset.
`define LFC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define LFC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lfc_pkg.sv
`timescale 1ns / 1ps
package lfc_pkg;
  localparam int Entries = 16;
  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int CntW = $clog2(Entries + 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_APPLY,
    ST_OUT
  } state_t;

  // One memory word holds a whole entry.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] freq;
    logic [31:0] stamp;
  } entry_t;
endpackage

>>> rtl/lfu_cache_with_timeout_unit.sv
`timescale 1ns / 1ps
`include "lfu_cache_with_timeout_unit_defines.svh"
// Fully associative key/value cache of 16 entries with least-frequently-used
// replacement; ties go to the entry that was touched longest ago, then to the
// lowest slot. Each transaction is a get or a put. Every transaction on an
// enabled cache advances a tick counter and first drops the single oldest entry
// if it has gone untouched for more than idle_timeout ticks. A get produces one
// output transaction (hit flag and value, -1 on a miss); a put produces none.
// The entries live in one synchronous memory with a registered read.
// A transaction is accepted (the read of entry 0 is issued at the accepting
// edge), then the 16 entries are compared (one read issued per cycle, one
// compared per cycle), then the result is written back; a get then hands over
// its result, which the receiver may stall. On a cache with capacity_in_use of
// zero no scan is made: a get goes straight to handing over a miss, and a put
// is dropped without any change. The timeout candidate is found during the
// same scan: it matters only when the key hits that very entry or when the
// victim choice sees it, both handled when the scan ends. Configuration goes
// through an APB-style port at byte addresses 0 (capacity_in_use) and 4
// (idle_timeout); write only while idle.
module lfu_cache_with_timeout_unit
  import lfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         operation,
  input  logic [31:0]  lookup_key,
  input  logic [31:0]  store_value,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         hit,
  output logic [31:0]  read_value,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  state_t state, state_next;

  logic [4:0]  capacity;
  logic [30:0] timeout;
  logic [31:0] tick;

  // Entry memory and valid flags (valid bits live in flip-flops).
  entry_t            mem [Entries];
  logic [Entries-1:0] valid;
  entry_t            rd_data;
  logic              mem_we;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;

  // Latched transaction.
  logic        op;
  logic [31:0] key;
  logic [31:0] val;

  // Scan bookkeeping.
  logic [IdxW:0]   rd_ptr;    // address being read, wide enough to hold Entries
  logic [IdxW-1:0] cmp_idx;   // index of the word in rd_data
  logic            found;
  logic [IdxW-1:0] found_idx;
  entry_t          found_ent;
  logic            old_have;
  logic [IdxW-1:0] old_idx;
  logic [31:0]     old_age;
  // Best victim overall.
  logic            v1_have;
  logic [IdxW-1:0] v1_idx;
  logic [31:0]     v1_freq, v1_age;
  logic [31:0]     v1_prev_freq, v1_prev_age; // v1 before the current oldest took it
  logic            v1_prev_have;
  logic [IdxW-1:0] v1_prev_idx;

  logic        res_hit;
  logic [31:0] res_value;

  logic [4:0] cap_eff;
  assign cap_eff = (capacity > 5'(Entries)) ? 5'(Entries) : capacity;

  // APB
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_comb begin
    unique case (paddr[2])
      1'b0:    prdata = {27'd0, capacity};
      default: prdata = {1'b0, timeout};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
      timeout  <= 31'd1000;
    end else if (wr_en) begin
      if ({1'b0, paddr[2]} == REG_CAPACITY) capacity <= pwdata[4:0];
      if ({1'b0, paddr[2]} == REG_TIMEOUT)  timeout  <= pwdata[30:0];
    end
  end

  // Memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_ptr[IdxW-1:0]];
  end

  // Current word compare.
  logic [31:0] cur_age;
  logic        cur_v;
  logic        is_older, v_better_1;
  assign cur_v    = valid[cmp_idx];
  assign cur_age  = tick - rd_data.stamp;
  assign is_older = !old_have || (cur_age > old_age);
  assign v_better_1 = !v1_have || (rd_data.freq < v1_freq) ||
                      (rd_data.freq == v1_freq && cur_age > v1_age);

  logic scan_cmp;
  assign scan_cmp = (state == ST_SCAN && rd_ptr != '0) || state == ST_LAST;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      found    <= 1'b0;
      old_have <= 1'b0;
      v1_have  <= 1'b0;
      v1_prev_have <= 1'b0;
    end else if (scan_cmp && cur_v) begin
      if (rd_data.key == key && !found) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
        found_ent <= rd_data;
      end
      if (is_older) begin
        old_have <= 1'b1;
        old_idx  <= cmp_idx;
        old_age  <= cur_age;
      end
      // Keep v1 as best over all; keep v1_prev as best over all but the
      // current oldest candidate.
      if (is_older) begin
        // New oldest: best-excluding-it is the best over everything before.
        v1_prev_have <= v1_have;
        v1_prev_idx  <= v1_idx;
        v1_prev_freq <= v1_freq;
        v1_prev_age  <= v1_age;
      end else if (!v1_prev_have || (rd_data.freq < v1_prev_freq) ||
                   (rd_data.freq == v1_prev_freq && cur_age > v1_prev_age)) begin
        v1_prev_have <= 1'b1;
        v1_prev_idx  <= cmp_idx;
        v1_prev_freq <= rd_data.freq;
        v1_prev_age  <= cur_age;
      end
      if (v_better_1) begin
        v1_have <= 1'b1;
        v1_idx  <= cmp_idx;
        v1_freq <= rd_data.freq;
        v1_age  <= cur_age;
      end
    end
  end

  // Decision at the end of the scan.
  logic            expire;
  logic            hit_eff;
  logic [CntW-1:0] count;
  logic            vic_have;
  logic [IdxW-1:0] vic_idx;
  logic [Entries-1:0] valid_after_to, valid_after_ev;
  logic            free_have;
  logic [IdxW-1:0] free_idx;

  assign expire  = old_have && (old_age > {1'b0, timeout});
  assign hit_eff = found && !(expire && old_idx == found_idx);

  always_comb begin
    valid_after_to = valid;
    if (expire) valid_after_to[old_idx] = 1'b0;
    count = '0;
    for (int i = 0; i < Entries; i++) count = count + CntW'(valid_after_to[i]);
    if (expire) begin
      vic_have = v1_prev_have;
      vic_idx  = v1_prev_idx;
    end else begin
      vic_have = v1_have;
      vic_idx  = v1_idx;
    end
    valid_after_ev = valid_after_to;
    if (count >= cap_eff && vic_have)
      valid_after_ev[vic_idx] = 1'b0;
    free_have = 1'b0;
    free_idx  = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_after_ev[i]) begin
        free_have = 1'b1;
        free_idx  = IdxW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = (cap_eff == '0) ?
                                (operation == OP_GET ? ST_OUT : ST_IDLE) : ST_SCAN;
      ST_SCAN:  if (rd_ptr == (IdxW+1)'(Entries - 1)) state_next = ST_LAST;
      ST_LAST:  state_next = ST_APPLY;
      ST_APPLY: state_next = (op == OP_GET) ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    hit       = res_hit;
    read_value = res_value;
    mem_we  = 1'b0;
    wr_addr = found_idx;
    wr_data = found_ent;
    if (state == ST_APPLY) begin
      if (hit_eff) begin
        mem_we  = 1'b1;
        wr_data.freq  = (found_ent.freq == 32'hFFFF_FFFF) ? found_ent.freq
                                                          : found_ent.freq + 32'd1;
        wr_data.stamp = tick;
        if (op == OP_PUT) wr_data.value = val;
      end else if (op == OP_PUT && free_have) begin
        mem_we  = 1'b1;
        wr_addr = free_idx;
        wr_data = '{key: key, value: val, freq: 32'd1, stamp: tick};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tick  <= '0;
      valid <= '0;
      rd_ptr <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          // The read address rests at entry 0 while idle, so the word of entry 0
          // is fetched at the accepting edge.
          if (in_valid) begin
            op  <= operation;
            key <= lookup_key;
            val <= store_value;
            res_hit   <= 1'b0;
            res_value <= 32'hFFFF_FFFF;
            if (cap_eff != '0) begin
              tick   <= tick + 32'd1;
              rd_ptr <= (IdxW+1)'(1);
            end
          end
        end
        ST_SCAN: if (rd_ptr != (IdxW+1)'(Entries - 1)) rd_ptr <= rd_ptr + 1'b1;
        ST_LAST: rd_ptr <= '0;
        ST_APPLY: begin
          if (hit_eff) begin
            valid <= valid_after_to;
            res_hit   <= 1'b1;
            res_value <= found_ent.value;
          end else if (op == OP_PUT) begin
            valid <= valid_after_ev | (free_have ? (Entries'(1) << free_idx) : '0);
          end else begin
            valid <= valid_after_to;
          end
        end
        default: ;
      endcase
    end
  end

  // Word in rd_data belongs to the address issued in the previous cycle.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) cmp_idx <= '0;
    else if (scan_cmp)   cmp_idx <= cmp_idx + 1'b1;
  end

  `LFC_ASSERT_IMP(a_out_only_get, clk, rst, out_valid, op == OP_GET, "result for a put")
  `LFC_ASSERT_IMP(a_miss_value, clk, rst, out_valid && !hit, read_value == 32'hFFFF_FFFF,
                  "miss without -1")
  `LFC_ASSERT_NEXT(a_apply_leaves, clk, rst, state == ST_APPLY,
                   state == ST_OUT || state == ST_IDLE, "bad exit from write-back")
  `LFC_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ready,
                  "accepting while busy")

endmodule

>>> verif/lfu_cache_checker.sv
`timescale 1ns / 1ps
module lfu_cache_checker
  import lfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [31:0] lookup_key,
  input  logic [31:0] store_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        hit,
  input  logic [31:0] read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          gets_seen,
  output int          hits_seen
);
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
  } lookup_t;

  lookup_t     answers[$];
  logic [4:0]  cap_reg;
  logic [30:0] timeout_reg;
  logic        slot_used[Entries];
  logic [31:0] slot_key[Entries];
  logic [31:0] slot_val[Entries];
  logic [31:0] slot_freq[Entries];
  logic [31:0] slot_stamp[Entries];
  logic [31:0] ticks;

  assign pending = answers.size();

  // Applies one get or put to the shadow cache; gets queue their answer.
  task automatic cache_apply(input logic op, input logic [31:0] k, input logic [31:0] v);
    int cap, at, cnt, vic;
    logic fnd;
    lookup_t r;
    cap = (cap_reg > Entries) ? Entries : cap_reg;
    if (cap == 0) begin
      if (op == OP_GET) begin
        r.hit = 1'b0; r.value = '1; answers.push_back(r);
      end
      return;
    end
    ticks = ticks + 32'd1;
    at = -1;
    for (int i = 0; i < Entries; i++)
      if (slot_used[i] && (at < 0 || ticks - slot_stamp[i] > ticks - slot_stamp[at])) at = i;
    if (at >= 0 && ticks - slot_stamp[at] > {1'b0, timeout_reg}) slot_used[at] = 1'b0;
    fnd = 1'b0;
    for (int i = 0; i < Entries; i++)
      if (!fnd && slot_used[i] && slot_key[i] == k) begin
        fnd = 1'b1; at = i;
      end
    if (fnd) begin
      if (slot_freq[at] != '1) slot_freq[at]++;
      slot_stamp[at] = ticks;
      if (op == OP_PUT) slot_val[at] = v;
      else begin
        r.hit = 1'b1; r.value = slot_val[at]; answers.push_back(r);
      end
      return;
    end
    if (op == OP_GET) begin
      r.hit = 1'b0; r.value = '1; answers.push_back(r);
      return;
    end
    cnt = 0;
    for (int i = 0; i < Entries; i++) if (slot_used[i]) cnt++;
    if (cnt >= cap) begin
      vic = -1;
      for (int i = 0; i < Entries; i++)
        if (slot_used[i] && (vic < 0 || slot_freq[i] < slot_freq[vic] ||
            (slot_freq[i] == slot_freq[vic] &&
             ticks - slot_stamp[i] > ticks - slot_stamp[vic]))) vic = i;
      if (vic >= 0) slot_used[vic] = 1'b0;
    end
    for (int i = 0; i < Entries; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1; slot_key[i] = k; slot_val[i] = v;
        slot_freq[i] = 32'd1; slot_stamp[i] = ticks;
        break;
      end
  endtask

  always @(posedge clk) begin
    lookup_t e;
    if (rst) begin
      answers.delete();
      cap_reg = 5'd16;
      timeout_reg = 31'd1000;
      ticks = '0;
      fail_count = 0;
      gets_seen = 0;
      hits_seen = 0;
      for (int i = 0; i < Entries; i++) slot_used[i] = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2:2] == REG_CAPACITY[0]) cap_reg = pwdata[4:0];
        else timeout_reg = pwdata[30:0];
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $error("unexpected result transaction hit=%0b value=%h", hit, read_value);
          fail_count++;
        end else begin
          e = answers.pop_front();
          gets_seen++;
          if (hit) hits_seen++;
          if (hit !== e.hit) begin
            $error("hit: expected %0b, actual %0b", e.hit, hit);
            fail_count++;
          end
          if (read_value !== e.value) begin
            $error("read_value: expected %h, actual %h", e.value, read_value);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) cache_apply(operation, lookup_key, store_value);
    end
  end
endmodule

>>> verif/tb_lfu_cache_with_timeout_unit.sv
`timescale 1ns / 1ps
module tb_lfu_cache_with_timeout_unit;
  import lfc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_GET;
  logic [31:0] lookup_key = '0;
  logic [31:0] store_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        hit;
  logic [31:0] read_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, gets_seen, hits_seen;
  int          send_idle_pct = 6;   // percent of cycles the sender holds back
  int          recv_idle_pct = 53;  // percent of cycles the receiver stalls
  int          hold_off = 0;        // cycles left in a long forced receiver stall
  logic        hold_req = 1'b0;     // asks the receiver for one long stall
  logic        hold_taken = 1'b0;   // the long stall has been started
  int          cycle_count = 0;
  int          sent = 0;
  logic [31:0] key_pool[8];         // a small key set so hits are frequent

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lfu_cache_with_timeout_unit dut (.*);

  lfu_cache_checker checker_i (.*);

  // The receiver stalls at random, or for a counted stretch when asked.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off   <= 400;
      out_ready  <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run limit, far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("tb_lfu_cache_with_timeout_unit failed");
      $finish;
    end
  end

  // One register write: a setup phase, then an access phase.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx[0], 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one transaction and holds it until the block takes it. Valid stays
  // high into the next transaction unless the sender decides to idle.
  task automatic send_op(input logic op, input logic [31:0] k, input logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1; operation <= op; lookup_key <= k; store_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stops offering, waits until every get has been answered, then lets the
  // block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_op();
    logic [31:0] k;
    logic        op;
    op = 1'($urandom_range(1));
    if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)];
    else k = $urandom();
    send_op(op, k, $urandom());
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, both operations, disabled cache, timeouts, evictions.
    send_op(OP_GET, 32'h8000_0000, '0);
    send_op(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(OP_GET, 32'h8000_0000, '0);
    send_op(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(OP_GET, 32'h7FFF_FFFF, '0);
    drain();
    reg_write(REG_CAPACITY, 32'd0);
    send_op(OP_PUT, 32'd5, 32'd5);
    send_op(OP_GET, 32'h8000_0000, '0);
    drain();
    reg_write(REG_CAPACITY, 32'd31);     // clamps to the full size
    reg_write(REG_TIMEOUT, 32'd0);       // each transaction drops the oldest entry
    send_op(OP_PUT, 32'd1, 32'd11);
    send_op(OP_PUT, 32'd2, 32'd22);
    send_op(OP_GET, 32'd1, '0);
    send_op(OP_GET, 32'd2, '0);
    drain();
    reg_write(REG_TIMEOUT, 32'h7FFF_FFFF);
    reg_write(REG_CAPACITY, 32'd2);      // small capacity: victims on put misses
    for (int i = 0; i < 5; i++) send_op(OP_PUT, 32'd100 + i, i);
    send_op(OP_GET, 32'd104, '0);
    send_op(OP_GET, 32'd100, '0);
    drain();

    // Random phases over several settings; idling profile changes every four phases.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin send_idle_pct = 53; recv_idle_pct = 6; end
      if (phase == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      case (phase % 4)
        0: begin reg_write(REG_CAPACITY, 32'd1); reg_write(REG_TIMEOUT, 32'd7); end
        1: begin
          reg_write(REG_CAPACITY, $urandom_range(16, 2));
          reg_write(REG_TIMEOUT, $urandom_range(40, 3));
        end
        2: begin reg_write(REG_CAPACITY, 32'd16); reg_write(REG_TIMEOUT, 32'h7FFF_FFFF); end
        default: begin
          reg_write(REG_CAPACITY, $urandom_range(5, 3));
          reg_write(REG_TIMEOUT, 32'd1000);
        end
      endcase
      if (phase == 2) hold_req <= 1'b1;  // long stall so the block backs up
      for (int n = 0; n < 80; n++) random_op();
      drain();
    end

    $display("Sent %0d transactions; %0d gets answered, %0d of them hits.",
             sent, gets_seen, hits_seen);
    if (fail_count == 0) $display("tb_lfu_cache_with_timeout_unit passed");
    else $display("tb_lfu_cache_with_timeout_unit failed");
    $finish;
  end
endmodule
